FILE: hdl/ipbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipbt_pkg
// Shared types, codes and helpers of the IPv4 wildcard ban table.
// ----------------------------------------------------------------------------
package ipbt_pkg;

    // default number of ban slots
    localparam int DEFAULT_TABLE_DEPTH = 64;

    // ids run 0..65534; this value means none left
    localparam logic [15:0] ID_LIMIT = 16'hFFFF;

    // request commands
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CHECK  = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_UPDATED    = 3'd1,
        ST_BANNED     = 3'd2,
        ST_NOT_BANNED = 3'd3,
        ST_REMOVED    = 3'd4,
        ST_NOT_FOUND  = 3'd5,
        ST_FULL       = 3'd6
    } t_status;

    // control sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DEL,
        S_DONE
    } t_state;

    // one ban slot as stored in the slot memory
    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [3:0]  mask;
        logic [31:0] expiry;
        logic [15:0] id;
    } t_entry;

    // octet mask to bit mask; octet 0 sits in bits 31..24
    function automatic logic [31:0] octet_bits(input logic [3:0] mask);
        return {{8{mask[0]}}, {8{mask[1]}}, {8{mask[2]}}, {8{mask[3]}}};
    endfunction

endpackage

FILE: hdl/ipbt_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipbt_slot_ram
// Ban slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ipbt_slot_ram #(
    parameter int TABLE_DEPTH = ipbt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IW          = $clog2(TABLE_DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IW-1:0]   i_waddr,
    input  ipbt_pkg::t_entry i_wdata,
    input  logic [IW-1:0]   i_raddr,
    output ipbt_pkg::t_entry o_rdata
);

    ipbt_pkg::t_entry r_mem [TABLE_DEPTH];
    ipbt_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ipv4_wildcard_ban_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_wildcard_ban_table
// IPv4 ban table with per-octet wildcards, expiry and newest-first matching.
// ----------------------------------------------------------------------------
// One request at a time. Each add, remove or check walks the slot memory once,
// one slot per cycle through its single read port. A check that has to drop
// expired bans newer than its answer walks the memory a second time to clear
// them. Command three skips the walk and goes straight to its result. After
// reset the block runs a clearing pass through the memory and holds o_in_stall
// high until it is done. The result register lets a new request be accepted
// while the previous result is still stalled.
module ipv4_wildcard_ban_table #(
    parameter int TABLE_DEPTH = ipbt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_ip_address,
    input  logic [3:0]  i_octet_mask,
    input  logic [31:0] i_expire_time,
    input  logic [31:0] i_now_seconds,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_result_id,
    output logic        o_is_permanent,
    output logic [31:0] o_remaining_seconds
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] CNT_END = CW'(TABLE_DEPTH);

    // sequencer and walk counter
    ipbt_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_rvalid;
    logic [IW-1:0]    r_ridx;

    // captured request
    ipbt_pkg::t_cmd   r_cmd;
    logic [31:0]      r_addr;
    logic [3:0]       r_mask;
    logic [31:0]      r_expire;
    logic [31:0]      r_now;

    // search tracking
    logic             r_best_found, n_best_found;
    logic [IW-1:0]    r_best_idx, n_best_idx;
    logic [15:0]      r_best_id, n_best_id;
    logic [31:0]      r_best_exp, n_best_exp;
    logic             r_free_found, n_free_found;
    logic [IW-1:0]    r_free_idx, n_free_idx;
    logic             r_exp_found, n_exp_found;
    logic [15:0]      r_exp_max, n_exp_max;
    logic [15:0]      r_next_id, n_next_id;

    // pending result
    ipbt_pkg::t_status r_res_status, n_res_status;
    logic [15:0]      r_res_id, n_res_id;
    logic             r_res_perm, n_res_perm;
    logic [31:0]      r_res_remain, n_res_remain;

    // output register
    logic             r_out_valid;
    ipbt_pkg::t_status r_out_status;
    logic [15:0]      r_out_id;
    logic             r_out_perm;
    logic [31:0]      r_out_remain;

    // memory ports
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    ipbt_pkg::t_entry mem_wdata;
    logic [IW-1:0]    mem_raddr;
    ipbt_pkg::t_entry rd;

    logic in_accept, out_free, walking, issuing, walk_done, del_needed;
    logic e_match, e_same, e_expired, e_newer, e_exp_newer;

    ipbt_slot_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    // handshake and walk control
    assign in_accept  = i_in_valid && (r_state == ipbt_pkg::S_IDLE);
    assign o_in_stall = (r_state != ipbt_pkg::S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign walking    = (r_state == ipbt_pkg::S_SCAN) || (r_state == ipbt_pkg::S_DEL);
    assign issuing    = walking && (r_cnt < CNT_END);
    assign walk_done  = walking && !issuing && !r_rvalid;
    assign mem_raddr  = issuing ? r_cnt[IW-1:0] : '0;

    // slot compare against the captured request
    assign e_match     = rd.valid &&
                         (((rd.address ^ r_addr) & ipbt_pkg::octet_bits(rd.mask)) == '0);
    assign e_same      = rd.valid && (rd.mask == r_mask) && (rd.address == r_addr);
    assign e_expired   = (rd.expiry != '0) && (r_now >= rd.expiry);
    assign e_newer     = !r_best_found || (rd.id > r_best_id);
    assign e_exp_newer = !r_exp_found || (rd.id > r_exp_max);

    // expired matches newer than the answer must be dropped
    assign del_needed  = r_exp_found && (!r_best_found || (r_exp_max > r_best_id));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipbt_pkg::S_CLEAR: begin
                if (r_cnt == CNT_END) n_state = ipbt_pkg::S_IDLE;
            end
            ipbt_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (ipbt_pkg::t_cmd'(i_command) == ipbt_pkg::CMD_NONE) begin
                        n_state = ipbt_pkg::S_DONE;
                    end else begin
                        n_state = ipbt_pkg::S_SCAN;
                    end
                end
            end
            ipbt_pkg::S_SCAN: begin
                if (walk_done) begin
                    if (r_cmd == ipbt_pkg::CMD_CHECK && del_needed) begin
                        n_state = ipbt_pkg::S_DEL;
                    end else begin
                        n_state = ipbt_pkg::S_DONE;
                    end
                end
            end
            ipbt_pkg::S_DEL: begin
                if (walk_done) n_state = ipbt_pkg::S_DONE;
            end
            ipbt_pkg::S_DONE: begin
                if (out_free) n_state = ipbt_pkg::S_IDLE;
            end
            default: n_state = ipbt_pkg::S_CLEAR;
        endcase
    end

    // datapath: counter, search tracking, memory writes, result
    always_comb begin
        n_cnt        = r_cnt;
        n_best_found = r_best_found;
        n_best_idx   = r_best_idx;
        n_best_id    = r_best_id;
        n_best_exp   = r_best_exp;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_exp_found  = r_exp_found;
        n_exp_max    = r_exp_max;
        n_next_id    = r_next_id;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_perm   = r_res_perm;
        n_res_remain = r_res_remain;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;

        unique case (r_state)
            ipbt_pkg::S_CLEAR: begin
                // invalidate every slot after reset
                if (r_cnt < CNT_END) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cnt[IW-1:0];
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            ipbt_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_cnt        = '0;
                    n_best_found = 1'b0;
                    n_free_found = 1'b0;
                    n_exp_found  = 1'b0;
                    n_res_status = ipbt_pkg::ST_NOT_FOUND;
                    n_res_id     = '0;
                    n_res_perm   = 1'b0;
                    n_res_remain = '0;
                end
            end
            ipbt_pkg::S_SCAN: begin
                if (issuing) n_cnt = r_cnt + 1'b1;
                // evaluate the slot read in the previous cycle
                if (r_rvalid) begin
                    case (r_cmd)
                        ipbt_pkg::CMD_ADD: begin
                            if (e_same && !r_best_found) begin
                                n_best_found = 1'b1;
                                n_best_idx   = r_ridx;
                                n_best_id    = rd.id;
                            end
                            if (!rd.valid && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_ridx;
                            end
                        end
                        ipbt_pkg::CMD_CHECK: begin
                            if (e_match && !e_expired && e_newer) begin
                                n_best_found = 1'b1;
                                n_best_id    = rd.id;
                                n_best_exp   = rd.expiry;
                            end
                            if (e_match && e_expired && e_exp_newer) begin
                                n_exp_found = 1'b1;
                                n_exp_max   = rd.id;
                            end
                        end
                        ipbt_pkg::CMD_REMOVE: begin
                            if (e_match && e_newer) begin
                                n_best_found = 1'b1;
                                n_best_idx   = r_ridx;
                                n_best_id    = rd.id;
                            end
                        end
                        default: ;
                    endcase
                end
                // walk finished: commit any add or remove write and form the result
                if (walk_done) begin
                    n_cnt = '0;
                    case (r_cmd)
                        ipbt_pkg::CMD_ADD: begin
                            if (r_best_found) begin
                                mem_we       = 1'b1;
                                mem_waddr    = r_best_idx;
                                mem_wdata    = '{1'b1, r_addr, r_mask, r_expire, r_best_id};
                                n_res_status = ipbt_pkg::ST_UPDATED;
                                n_res_id     = r_best_id;
                            end else if (!r_free_found || r_next_id == ipbt_pkg::ID_LIMIT) begin
                                n_res_status = ipbt_pkg::ST_FULL;
                            end else begin
                                mem_we       = 1'b1;
                                mem_waddr    = r_free_idx;
                                mem_wdata    = '{1'b1, r_addr, r_mask, r_expire, r_next_id};
                                n_res_status = ipbt_pkg::ST_ADDED;
                                n_res_id     = r_next_id;
                                n_next_id    = r_next_id + 1'b1;
                            end
                        end
                        ipbt_pkg::CMD_CHECK: begin
                            if (r_best_found) begin
                                n_res_status = ipbt_pkg::ST_BANNED;
                                n_res_id     = r_best_id;
                                n_res_perm   = (r_best_exp == '0);
                                n_res_remain = (r_best_exp == '0) ? '0 : r_best_exp - r_now;
                            end else begin
                                n_res_status = ipbt_pkg::ST_NOT_BANNED;
                            end
                        end
                        ipbt_pkg::CMD_REMOVE: begin
                            if (r_best_found) begin
                                mem_we       = 1'b1;
                                mem_waddr    = r_best_idx;
                                n_res_status = ipbt_pkg::ST_REMOVED;
                                n_res_id     = r_best_id;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ipbt_pkg::S_DEL: begin
                if (issuing) n_cnt = r_cnt + 1'b1;
                // drop expired matches newer than the answer
                if (r_rvalid && e_match && e_expired && e_newer) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_ridx;
                end
            end
            ipbt_pkg::S_DONE: ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ipbt_pkg::S_CLEAR;
            r_cnt       <= '0;
            r_rvalid    <= 1'b0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rvalid  <= issuing;
            r_next_id <= n_next_id;
            if (r_state == ipbt_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ridx       <= mem_raddr;
        r_best_found <= n_best_found;
        r_best_idx   <= n_best_idx;
        r_best_id    <= n_best_id;
        r_best_exp   <= n_best_exp;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_exp_found  <= n_exp_found;
        r_exp_max    <= n_exp_max;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_perm   <= n_res_perm;
        r_res_remain <= n_res_remain;
        // capture the request; add stores the wildcard-cleared key
        if (in_accept) begin
            r_cmd    <= ipbt_pkg::t_cmd'(i_command);
            r_mask   <= i_octet_mask;
            r_expire <= i_expire_time;
            r_now    <= i_now_seconds;
            if (ipbt_pkg::t_cmd'(i_command) == ipbt_pkg::CMD_ADD) begin
                r_addr <= i_ip_address & ipbt_pkg::octet_bits(i_octet_mask);
            end else begin
                r_addr <= i_ip_address;
            end
        end
        // load the result register
        if (r_state == ipbt_pkg::S_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_perm   <= r_res_perm;
            r_out_remain <= r_res_remain;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out_status;
    assign o_result_id         = r_out_id;
    assign o_is_permanent      = r_out_perm;
    assign o_remaining_seconds = r_out_remain;

endmodule
